// File: rtl/assert_macros.svh
// assertion helpers shared by the line framer modules
// each use expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LFRB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
`define LFRB_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define LFRB_ASSERT(lbl, prop)
`define LFRB_NEVER(lbl, cond)
`endif

`endif

// File: rtl/lfrb_pkg.sv
package lfrb_pkg;

    localparam int LINE_SLOTS = 8;
    localparam int LINE_BYTES = 64;

    localparam int SLOT_W     = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int LEN_W      = $clog2(LINE_BYTES);
    localparam int DATA_AW    = SLOT_W + LEN_W;
    localparam int DATA_DEPTH = LINE_SLOTS * (2 ** LEN_W);
    localparam int CHAR_W     = 8;
    localparam int LEFT_W     = 3;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [LEFT_W-1:0] LEFT_MAX = 3'd7;

    typedef enum logic {
        CMD_RECV  = 1'b0,
        CMD_FETCH = 1'b1
    } cmd_t;

    typedef enum logic {
        ST_CHAR    = 1'b0,
        ST_NO_LINE = 1'b1
    } status_t;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] data_byte;
    } in_t;

    typedef struct packed {
        logic              status;
        logic [CHAR_W-1:0] line_char;
        logic              last;
        logic [LEFT_W-1:0] lines_left;
    } result_t;

    // fetch job handed from front to back
    typedef struct packed {
        logic              no_line;
        logic [SLOT_W-1:0] slot;
        logic [LEFT_W-1:0] left;
    } job_t;

    // slot the back is still reading out
    typedef struct packed {
        logic              busy;
        logic [SLOT_W-1:0] slot;
    } back_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LEN,
        B_READ,
        B_PUSH,
        B_NOLINE
    } back_state_t;

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(LINE_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/line_framer_ring_buffer.sv
// receive items: one per cycle, no result; input stalls while the job queue is full or
//   the fill row is a slot that the back still has to read out
// fetch items: when the back takes the job it reads the line length, then reads and pushes
//   each character in turn from the registered store read, holding while the result queue
//   is full; up to two more fetches wait in the job queue
// reset: async active-low rst_n clears pointers, fill count and queues; rams not cleared
module line_framer_ring_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lfrb_pkg::in_t     item,
    output logic              empty,
    input  logic              pop,
    output lfrb_pkg::result_t result
);

    // front to ram write ports
    logic                            data_wr_en;
    logic [lfrb_pkg::DATA_AW-1:0]    data_wr_addr;
    logic [lfrb_pkg::CHAR_W-1:0]     data_wr_data;
    logic                            len_wr_en;
    logic [lfrb_pkg::SLOT_W-1:0]     len_wr_addr;
    logic [lfrb_pkg::LEN_W-1:0]      len_wr_data;

    // back to ram read ports
    logic                            data_rd_en;
    logic [lfrb_pkg::DATA_AW-1:0]    data_rd_addr;
    logic [lfrb_pkg::CHAR_W-1:0]     data_rd_data;
    logic                            len_rd_en;
    logic [lfrb_pkg::SLOT_W-1:0]     len_rd_addr;
    logic [lfrb_pkg::LEN_W-1:0]      len_rd_data;

    // job queue between front and back
    logic                            job_push;
    lfrb_pkg::job_t                  job_in;
    logic                            jobq_full;
    logic                            job_pop;
    lfrb_pkg::job_t                  job_out;
    logic                            jobq_empty;
    logic [lfrb_pkg::SLOT_W-1:0]     guard_slot;
    logic                            jobq_hit;
    lfrb_pkg::back_status_t          back_st;

    // front: takes items, builds the current line, commits it and issues fetch jobs
    lfrb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .data_wr_en   (data_wr_en),
        .data_wr_addr (data_wr_addr),
        .data_wr_data (data_wr_data),
        .len_wr_en    (len_wr_en),
        .len_wr_addr  (len_wr_addr),
        .len_wr_data  (len_wr_data),
        .job_push     (job_push),
        .job          (job_in),
        .jobq_full    (jobq_full),
        .guard_slot   (guard_slot),
        .jobq_hit     (jobq_hit),
        .back_st      (back_st)
    );

    // short job queue, also reports whether a queued job still owns the fill slot
    lfrb_job_queue u_job_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (job_push),
        .wr_job     (job_in),
        .q_full     (jobq_full),
        .rd_en      (job_pop),
        .rd_job     (job_out),
        .q_empty    (jobq_empty),
        .probe_slot (guard_slot),
        .probe_hit  (jobq_hit)
    );

    // line store: one row per slot, row stride a power of two
    lfrb_ram #(
        .WIDTH (lfrb_pkg::CHAR_W),
        .DEPTH (lfrb_pkg::DATA_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr_data),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd_data)
    );

    // character count of each committed line
    lfrb_ram #(
        .WIDTH (lfrb_pkg::LEN_W),
        .DEPTH (lfrb_pkg::LINE_SLOTS)
    ) u_line_length (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (len_wr_addr),
        .wr_data (len_wr_data),
        .rd_en   (len_rd_en),
        .rd_addr (len_rd_addr),
        .rd_data (len_rd_data)
    );

    // back: streams each fetched line out through a small result queue
    lfrb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .jobq_empty   (jobq_empty),
        .job          (job_out),
        .job_pop      (job_pop),
        .len_rd_en    (len_rd_en),
        .len_rd_addr  (len_rd_addr),
        .len_rd_data  (len_rd_data),
        .data_rd_en   (data_rd_en),
        .data_rd_addr (data_rd_addr),
        .data_rd_data (data_rd_data),
        .back_st      (back_st),
        .result       (result),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

// File: rtl/lfrb_ram.sv
module lfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/lfrb_job_queue.sv
module lfrb_job_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  lfrb_pkg::job_t                 wr_job,
    output logic                           q_full,
    input  logic                           rd_en,
    output lfrb_pkg::job_t                 rd_job,
    output logic                           q_empty,
    input  logic [lfrb_pkg::SLOT_W-1:0]    probe_slot,
    output logic                           probe_hit
);

    lfrb_pkg::job_t entry_reg [2];
    logic [1:0]     valid_reg;
    logic [1:0]     valid_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;

    assign q_full  = &valid_reg;
    assign q_empty = !valid_reg[rd_ptr_reg];
    assign rd_job  = entry_reg[rd_ptr_reg];

    // a queued line slot must not be refilled before it is read out
    always_comb
    begin
        probe_hit = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            if (valid_reg[i] && !entry_reg[i].no_line && entry_reg[i].slot == probe_slot)
            begin
                probe_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (rd_en)
        begin
            valid_next[rd_ptr_reg] = 1'b0;
        end
        if (wr_en)
        begin
            valid_next[wr_ptr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

// File: rtl/lfrb_front.sv
`include "assert_macros.svh"

module lfrb_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  lfrb_pkg::in_t                   item,
    output logic                            data_wr_en,
    output logic [lfrb_pkg::DATA_AW-1:0]    data_wr_addr,
    output logic [lfrb_pkg::CHAR_W-1:0]     data_wr_data,
    output logic                            len_wr_en,
    output logic [lfrb_pkg::SLOT_W-1:0]     len_wr_addr,
    output logic [lfrb_pkg::LEN_W-1:0]      len_wr_data,
    output logic                            job_push,
    output lfrb_pkg::job_t                  job,
    input  logic                            jobq_full,
    output logic [lfrb_pkg::SLOT_W-1:0]     guard_slot,
    input  logic                            jobq_hit,
    input  lfrb_pkg::back_status_t          back_st
);

    localparam int SW = lfrb_pkg::SLOT_W;
    localparam int LW = lfrb_pkg::LEN_W;
    localparam int CW = lfrb_pkg::SLOT_W + 1;

    logic [LW-1:0] fill_count_reg;
    logic [LW-1:0] fill_count_next;
    logic [SW-1:0] write_slot_reg;
    logic [SW-1:0] write_slot_next;
    logic [SW-1:0] read_slot_reg;
    logic [SW-1:0] read_slot_next;

    logic          acc;
    logic          guard_hit;
    logic          ring_empty;
    logic [SW-1:0] ws_after;
    logic [SW-1:0] rs_after;
    logic [CW-1:0] diff;
    logic [lfrb_pkg::LEFT_W-1:0] left;

    assign ws_after   = lfrb_pkg::slot_after(write_slot_reg);
    assign rs_after   = lfrb_pkg::slot_after(read_slot_reg);
    assign ring_empty = (write_slot_reg == read_slot_reg);

    // the fill row must not be one that the back still has to read
    assign guard_slot = write_slot_reg;
    assign guard_hit  = jobq_hit || (back_st.busy && back_st.slot == write_slot_reg);
    assign full       = guard_hit || jobq_full;
    assign acc        = push && !full;

    // lines stored once the oldest one is taken, saturated
    always_comb
    begin
        diff = {1'b0, write_slot_reg} - {1'b0, rs_after};
        if (write_slot_reg < rs_after)
        begin
            diff = diff + CW'(lfrb_pkg::LINE_SLOTS);
        end
        if (diff > CW'(7))
        begin
            left = lfrb_pkg::LEFT_MAX;
        end
        else
        begin
            left = lfrb_pkg::LEFT_W'(diff);
        end
    end

    assign data_wr_addr = {write_slot_reg, fill_count_reg};
    assign data_wr_data = item.data_byte;
    assign len_wr_addr  = write_slot_reg;
    assign len_wr_data  = fill_count_reg;

    always_comb
    begin
        fill_count_next = fill_count_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        data_wr_en      = 1'b0;
        len_wr_en       = 1'b0;
        job_push        = 1'b0;
        job.no_line     = 1'b0;
        job.slot        = read_slot_reg;
        job.left        = left;
        if (acc)
        begin
            case (item.cmd)
                lfrb_pkg::CMD_RECV:
                begin
                    if (item.data_byte == lfrb_pkg::CH_CR)
                    begin
                        fill_count_next = fill_count_reg;
                    end
                    else if (item.data_byte == lfrb_pkg::CH_LF)
                    begin
                        if (fill_count_reg != '0)
                        begin
                            if (ws_after != read_slot_reg)
                            begin
                                len_wr_en       = 1'b1;
                                write_slot_next = ws_after;
                            end
                            fill_count_next = '0;
                        end
                    end
                    else if (fill_count_reg < LW'(lfrb_pkg::LINE_BYTES - 1))
                    begin
                        data_wr_en      = 1'b1;
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                end
                lfrb_pkg::CMD_FETCH:
                begin
                    job_push = 1'b1;
                    if (ring_empty)
                    begin
                        job.no_line = 1'b1;
                        job.slot    = '0;
                        job.left    = '0;
                    end
                    else
                    begin
                        read_slot_next = rs_after;
                    end
                end
                default:
                begin
                    job_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
        end
    end

    `LFRB_NEVER(a_commit_into_full, len_wr_en && ws_after == read_slot_reg)
    `LFRB_ASSERT(a_read_step, job_push && !job.no_line |=> read_slot_reg == $past(rs_after))

endmodule

// File: rtl/lfrb_back.sv
`include "assert_macros.svh"

module lfrb_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            jobq_empty,
    input  lfrb_pkg::job_t                  job,
    output logic                            job_pop,
    output logic                            len_rd_en,
    output logic [lfrb_pkg::SLOT_W-1:0]     len_rd_addr,
    input  logic [lfrb_pkg::LEN_W-1:0]      len_rd_data,
    output logic                            data_rd_en,
    output logic [lfrb_pkg::DATA_AW-1:0]    data_rd_addr,
    input  logic [lfrb_pkg::CHAR_W-1:0]     data_rd_data,
    output lfrb_pkg::back_status_t          back_st,
    output lfrb_pkg::result_t               result,
    output logic                            empty,
    input  logic                            pop
);

    localparam int SW = lfrb_pkg::SLOT_W;
    localparam int LW = lfrb_pkg::LEN_W;

    lfrb_pkg::back_state_t state_reg;
    lfrb_pkg::back_state_t state_next;

    logic [SW-1:0]               slot_reg;
    logic [SW-1:0]               slot_next;
    logic [lfrb_pkg::LEFT_W-1:0] left_reg;
    logic [lfrb_pkg::LEFT_W-1:0] left_next;
    logic [LW-1:0]               len_reg;
    logic [LW-1:0]               len_next;
    logic [LW-1:0]               idx_reg;
    logic [LW-1:0]               idx_next;
    logic [LW-1:0]               idx_inc;
    logic                        last_char;

    lfrb_pkg::result_t out_reg [2];
    logic [1:0]        out_valid_reg;
    logic [1:0]        out_valid_next;
    logic              out_wr_ptr_reg;
    logic              out_rd_ptr_reg;
    logic              out_full;
    logic              out_push;
    logic              out_pop;
    lfrb_pkg::result_t out_data;

    assign idx_inc   = idx_reg + 1'b1;
    assign last_char = (idx_inc == len_reg);

    assign back_st.busy = (state_reg != lfrb_pkg::B_IDLE) && (state_reg != lfrb_pkg::B_NOLINE);
    assign back_st.slot = slot_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfrb_pkg::B_IDLE:
            begin
                if (!jobq_empty)
                begin
                    state_next = job.no_line ? lfrb_pkg::B_NOLINE : lfrb_pkg::B_LEN;
                end
            end
            lfrb_pkg::B_LEN:
            begin
                state_next = lfrb_pkg::B_READ;
            end
            lfrb_pkg::B_READ:
            begin
                if (!out_full)
                begin
                    state_next = lfrb_pkg::B_PUSH;
                end
            end
            lfrb_pkg::B_PUSH:
            begin
                state_next = last_char ? lfrb_pkg::B_IDLE : lfrb_pkg::B_READ;
            end
            lfrb_pkg::B_NOLINE:
            begin
                if (!out_full)
                begin
                    state_next = lfrb_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = lfrb_pkg::B_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        job_pop      = 1'b0;
        len_rd_en    = 1'b0;
        len_rd_addr  = job.slot;
        data_rd_en   = 1'b0;
        data_rd_addr = {slot_reg, idx_reg};
        out_push     = 1'b0;
        out_data     = '{status: lfrb_pkg::ST_CHAR, line_char: data_rd_data,
                         last: last_char, lines_left: left_reg};
        slot_next    = slot_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        case (state_reg)
            lfrb_pkg::B_IDLE:
            begin
                if (!jobq_empty)
                begin
                    job_pop   = 1'b1;
                    len_rd_en = !job.no_line;
                    slot_next = job.slot;
                    left_next = job.left;
                end
            end
            lfrb_pkg::B_LEN:
            begin
                len_next = len_rd_data;
                idx_next = '0;
            end
            lfrb_pkg::B_READ:
            begin
                data_rd_en = !out_full;
            end
            lfrb_pkg::B_PUSH:
            begin
                out_push = 1'b1;
                idx_next = idx_inc;
            end
            lfrb_pkg::B_NOLINE:
            begin
                out_push = !out_full;
                out_data = '{status: lfrb_pkg::ST_NO_LINE, line_char: '0,
                             last: 1'b1, lines_left: '0};
            end
            default:
            begin
                out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfrb_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        left_reg <= left_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
    end

    // two-entry result queue toward the consumer
    assign out_full = &out_valid_reg;
    assign empty    = !out_valid_reg[out_rd_ptr_reg];
    assign result   = out_reg[out_rd_ptr_reg];
    assign out_pop  = pop && !empty;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_pop)
        begin
            out_valid_next[out_rd_ptr_reg] = 1'b0;
        end
        if (out_push)
        begin
            out_valid_next[out_wr_ptr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_reg[out_wr_ptr_reg] <= out_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= '0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (out_push)
            begin
                out_wr_ptr_reg <= !out_wr_ptr_reg;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= !out_rd_ptr_reg;
            end
        end
    end

    `LFRB_NEVER(a_push_overflow, out_push && out_full)
    `LFRB_ASSERT(a_last_ends_job, out_push && out_data.last |=> state_reg == lfrb_pkg::B_IDLE)

endmodule
